@@ hdl/gbd_pkg.sv @@
// shared constants, types and the exponent factor table of the gaussian basis block
// no dependencies; every other file of the block imports it, but for the two channel interfaces
package gbd_pkg;

   // default number of fraction bits resolved through the factor table
   localparam int EXP_TABLE_BITS_DEF = 8;

   // fixed-point layout of the base-2 exponent
   localparam int FRAC_BITS = 20;

   // log2(e) in q.20 and ln(2) in q.30
   localparam logic [20:0] LOG2E_Q20 = 21'd1512775;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;

   // 1.0 in q2.30 and the half lsb used for rounding q30 products
   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [61:0] ROUND_Q30 = 62'd536870912;

   // slope rounding: half lsb of the final right shift by 22
   localparam logic [47:0] ROUND_SLOPE = 48'd2097152;

   // exponent flush threshold on bits [47:32] of beta*d^2
   localparam logic [15:0] FLUSH_HI = 16'd12;

   // saturation bounds of the slope magnitude
   localparam logic [25:0] MAG_POS_MAX = 26'd131071;
   localparam logic [25:0] MAG_NEG_MAX = 26'd131072;

   // basis value of exactly 1.0 in q1.15
   localparam logic [15:0] VALUE_ONE = 16'd32768;

   // register file
   localparam int          CSR_ADDR_BITS   = 3;
   localparam logic        REG_WIDTH_COEFF = 1'b0;
   localparam logic        REG_CENTER      = 1'b1;
   localparam logic [15:0] BETA_RESET      = 16'd256;
   localparam logic [15:0] CENTER_RESET    = 16'd0;

   typedef struct packed {
      logic [15:0] width_coeff;
      logic [15:0] center;
   } csr_regs_type;

   // one word in flight through the exponent pipe
   typedef struct packed {
      logic        neg;     // r below mu
      logic        zero;    // exponent too large, value flushes to zero
      logic [3:0]  k;       // integer part of the base-2 exponent
      logic [19:0] frac;    // fraction part of the base-2 exponent
      logic [30:0] m;       // running mantissa, q2.30
      logic [30:0] lofac;   // linear factor for the low fraction bits, q2.30
      logic [31:0] bad;     // beta*|d|, q12.20
   } exp_word_type;

   // factors 2^(-2^-(idx+1)) in q2.30
   function automatic logic [29:0] pow2_neg(input logic [3:0] idx);
      logic [29:0] res;
      case (idx)
         4'd0:    res = 30'd759250125;
         4'd1:    res = 30'd902905651;
         4'd2:    res = 30'd984625594;
         4'd3:    res = 30'd1028218693;
         4'd4:    res = 30'd1050733751;
         4'd5:    res = 30'd1062175491;
         4'd6:    res = 30'd1067942999;
         4'd7:    res = 30'd1070838486;
         4'd8:    res = 30'd1072289173;
         4'd9:    res = 30'd1073015252;
         4'd10:   res = 30'd1073378477;
         4'd11:   res = 30'd1073560135;
         default: res = 30'd0;
      endcase
      return res;
   endfunction

endpackage

@@ hdl/gbd_req_if.sv @@
// input channel of the gaussian basis block: one distance word per handshake
// no dependencies
interface gbd_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] distance;

   modport source (output valid, output distance, input ready);
   modport sink   (input valid, input distance, output ready);
endinterface

@@ hdl/gbd_rsp_if.sv @@
// result channel of the gaussian basis block: basis value and slope per word
// no dependencies
interface gbd_rsp_if;
   logic               valid;
   logic               ready;
   logic        [15:0] basis_value;
   logic signed [17:0] basis_slope;

   modport source (output valid, output basis_value, output basis_slope, input ready);
   modport sink   (input valid, input basis_value, input basis_slope, output ready);
endinterface

@@ hdl/gbd_csr.sv @@
// apb-style register file holding beta and mu
// depends on gbd_pkg
module gbd_csr import gbd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output csr_regs_type             regs
);

   csr_regs_type regs_ff;
   csr_regs_type regs_in;
   logic         wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register write decode on the word address
   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_WIDTH_COEFF: regs_in.width_coeff = pwdata[15:0];
            REG_CENTER:      regs_in.center      = pwdata[15:0];
            default:         regs_in             = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.width_coeff <= BETA_RESET;
         regs_ff.center      <= CENTER_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // read mux
   always_comb begin
      case (paddr[2])
         REG_WIDTH_COEFF: prdata = {16'd0, regs_ff.width_coeff};
         REG_CENTER:      prdata = {16'd0, regs_ff.center};
         default:         prdata = 32'd0;
      endcase
   end

   assign regs = regs_ff;

endmodule

@@ hdl/gbd_front.sv @@
// front of the pipe: distance offset, square, exponent scaling, base-2 split
// depends on gbd_pkg; four register stages
module gbd_front import gbd_pkg::*; #(
   parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [15:0]  distance,
   input  csr_regs_type regs,
   output logic         out_valid,
   output exp_word_type out_word
);

   localparam int LO_BITS  = FRAC_BITS - EXP_TABLE_BITS;
   localparam int LNP_BITS = LO_BITS + 30;

   // stage 1: |r - mu| and its square
   logic        s1_v_ff;
   logic        s1_neg_ff, s1_neg_in;
   logic [15:0] s1_ad_ff, s1_ad_in;
   logic [31:0] s1_ad2_ff, s1_ad2_in;

   always_comb begin
      s1_neg_in = distance < regs.center;
      s1_ad_in  = s1_neg_in ? (regs.center - distance) : (distance - regs.center);
      s1_ad2_in = 32'(s1_ad_in) * 32'(s1_ad_in);
   end

   // stage 2: t = beta*d^2, flush test, q.20 exponent
   logic        s2_v_ff;
   logic        s2_neg_ff;
   logic [15:0] s2_ad_ff;
   logic [47:0] s2_t;
   logic        s2_flush_ff, s2_flush_in;
   logic [23:0] s2_tq_ff, s2_tq_in;

   always_comb begin
      s2_t        = 48'(regs.width_coeff) * 48'(s1_ad2_ff);
      s2_flush_in = s2_t[47:32] >= FLUSH_HI;
      s2_tq_in    = s2_t[35:12];
   end

   // stage 3: base-2 exponent y = tq*log2(e), and beta*|d| for the slope
   logic        s3_v_ff;
   logic        s3_neg_ff;
   logic [44:0] s3_y_prod;
   logic [24:0] s3_y;
   logic        s3_zero_ff, s3_zero_in;
   logic [3:0]  s3_k_ff;
   logic [19:0] s3_f_ff;
   logic [31:0] s3_bad_ff, s3_bad_in;

   always_comb begin
      s3_y_prod  = 45'(s2_tq_ff) * 45'(LOG2E_Q20);
      s3_y       = s3_y_prod[44:20];
      s3_zero_in = s2_flush_ff | s3_y[24];
      s3_bad_in  = 32'(regs.width_coeff) * 32'(s2_ad_ff);
   end

   // stage 4: linear factor for the fraction bits below the table
   logic [LO_BITS-1:0]  s4_lo;
   logic [LNP_BITS-1:0] s4_lnp;
   exp_word_type        s4_word_ff, s4_word_in;
   logic                s4_v_ff;

   always_comb begin
      s4_lo            = s3_f_ff[LO_BITS-1:0];
      s4_lnp           = LNP_BITS'(s4_lo) * LNP_BITS'(LN2_Q30);
      s4_word_in.neg   = s3_neg_ff;
      s4_word_in.zero  = s3_zero_ff;
      s4_word_in.k     = s3_k_ff;
      s4_word_in.frac  = s3_f_ff;
      s4_word_in.m     = ONE_Q30;
      s4_word_in.lofac = ONE_Q30 - 31'(s4_lnp[LNP_BITS-1:20]);
      s4_word_in.bad   = s3_bad_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_neg_ff   <= s1_neg_in;
         s1_ad_ff    <= s1_ad_in;
         s1_ad2_ff   <= s1_ad2_in;
         s2_neg_ff   <= s1_neg_ff;
         s2_ad_ff    <= s1_ad_ff;
         s2_flush_ff <= s2_flush_in;
         s2_tq_ff    <= s2_tq_in;
         s3_neg_ff   <= s2_neg_ff;
         s3_zero_ff  <= s3_zero_in;
         s3_k_ff     <= s3_y[23:20];
         s3_f_ff     <= s3_y[19:0];
         s3_bad_ff   <= s3_bad_in;
         s4_word_ff  <= s4_word_in;
      end
   end

   assign out_valid = s4_v_ff;
   assign out_word  = s4_word_ff;

endmodule

@@ hdl/gbd_exp_stage.sv @@
// one table stage of the exponential: multiplies by 2^(-2^-STAGE_IDX) when
// that fraction bit is set; depends on gbd_pkg
module gbd_exp_stage import gbd_pkg::*; #(
   parameter int STAGE_IDX = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  exp_word_type in_word,
   output logic         out_valid,
   output exp_word_type out_word
);

   logic [29:0]  factor;
   logic [61:0]  prod;
   exp_word_type word_ff, word_in;
   logic         v_ff;

   // rounded q30 product, taken only when this fraction bit is set
   always_comb begin
      factor  = pow2_neg(4'(STAGE_IDX - 1));
      prod    = 62'(in_word.m) * 62'(factor) + ROUND_Q30;
      word_in = in_word;
      if (in_word.frac[FRAC_BITS - STAGE_IDX]) begin
         word_in.m = prod[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = v_ff;
   assign out_word  = word_ff;

endmodule

@@ hdl/gbd_back.sv @@
// back of the pipe: low-fraction factor, scale to q1.15, slope and
// saturation, then the output register with a skid stage; depends on gbd_pkg
module gbd_back import gbd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  exp_word_type       in_word,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic        [15:0] basis_value,
   output logic signed [17:0] basis_slope
);

   // stage b1: apply the linear factor
   logic        b1_v_ff;
   logic [61:0] b1_prod;
   logic [30:0] b1_m_ff;
   logic [3:0]  b1_k_ff;
   logic        b1_zero_ff;
   logic        b1_neg_ff;
   logic [31:0] b1_bad_ff;

   always_comb begin
      b1_prod = 62'(in_word.m) * 62'(in_word.lofac) + ROUND_Q30;
   end

   // stage b2: shift by 15+k with rounding
   logic        b2_v_ff;
   logic [31:0] b2_sum;
   logic [31:0] b2_shr;
   logic [15:0] b2_val_ff, b2_val_in;
   logic        b2_neg_ff;
   logic [31:0] b2_bad_ff;

   always_comb begin
      b2_sum    = 32'(b1_m_ff) + (32'd1 << (5'd14 + 5'(b1_k_ff)));
      b2_shr    = b2_sum >> (5'd15 + 5'(b1_k_ff));
      b2_val_in = b1_zero_ff ? 16'd0 : b2_shr[15:0];
   end

   // stage b3: slope magnitude beta*|d|*value, rounded
   logic        b3_v_ff;
   logic [47:0] b3_prod;
   logic [25:0] b3_mag_ff;
   logic [15:0] b3_val_ff;
   logic        b3_neg_ff;

   always_comb begin
      b3_prod = 48'(b2_bad_ff) * 48'(b2_val_ff) + ROUND_SLOPE;
   end

   // sign and saturation of the slope
   logic [25:0]        sat_mag;
   logic signed [17:0] pipe_slope;

   always_comb begin
      if (b3_mag_ff == 26'd0) begin
         sat_mag    = 26'd0;
         pipe_slope = 18'sd0;
      end else if (b3_neg_ff) begin
         sat_mag    = (b3_mag_ff > MAG_POS_MAX) ? MAG_POS_MAX : b3_mag_ff;
         pipe_slope = signed'(sat_mag[17:0]);
      end else begin
         sat_mag    = (b3_mag_ff > MAG_NEG_MAX) ? MAG_NEG_MAX : b3_mag_ff;
         pipe_slope = signed'(18'd0 - sat_mag[17:0]);
      end
   end

   // output register and skid stage
   logic               out_v_ff, out_v_in;
   logic        [15:0] out_val_ff, out_val_in;
   logic signed [17:0] out_slope_ff, out_slope_in;
   logic               skid_v_ff, skid_v_in;
   logic        [15:0] skid_val_ff, skid_val_in;
   logic signed [17:0] skid_slope_ff, skid_slope_in;
   logic               incoming;

   assign advance  = !skid_v_ff;
   assign incoming = b3_v_ff && advance;

   always_comb begin
      out_v_in      = out_v_ff;
      out_val_in    = out_val_ff;
      out_slope_in  = out_slope_ff;
      skid_v_in     = skid_v_ff;
      skid_val_in   = skid_val_ff;
      skid_slope_in = skid_slope_ff;
      if (!out_v_ff || rsp_ready) begin
         out_v_in     = skid_v_ff || incoming;
         out_val_in   = skid_v_ff ? skid_val_ff : b3_val_ff;
         out_slope_in = skid_v_ff ? skid_slope_ff : pipe_slope;
         skid_v_in    = 1'b0;
      end else if (incoming) begin
         skid_v_in     = 1'b1;
         skid_val_in   = b3_val_ff;
         skid_slope_in = pipe_slope;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff   <= 1'b0;
         b2_v_ff   <= 1'b0;
         b3_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (advance) begin
            b1_v_ff <= in_valid;
            b2_v_ff <= b1_v_ff;
            b3_v_ff <= b2_v_ff;
         end
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         b1_m_ff    <= b1_prod[60:30];
         b1_k_ff    <= in_word.k;
         b1_zero_ff <= in_word.zero;
         b1_neg_ff  <= in_word.neg;
         b1_bad_ff  <= in_word.bad;
         b2_val_ff  <= b2_val_in;
         b2_neg_ff  <= b1_neg_ff;
         b2_bad_ff  <= b1_bad_ff;
         b3_mag_ff  <= b3_prod[47:22];
         b3_val_ff  <= b2_val_ff;
         b3_neg_ff  <= b2_neg_ff;
      end
      out_val_ff    <= out_val_in;
      out_slope_ff  <= out_slope_in;
      skid_val_ff   <= skid_val_in;
      skid_slope_ff <= skid_slope_in;
   end

   assign rsp_valid   = out_v_ff;
   assign basis_value = out_val_ff;
   assign basis_slope = out_slope_ff;

endmodule

@@ hdl/gaussian_basis_with_derivative.sv @@
// gaussian radial basis value and derivative, top level; uses gbd_pkg, the
// channel interfaces, gbd_csr, gbd_front, gbd_exp_stage and gbd_back
// throughput: one word per cycle while the result channel is not stalled;
// the depth is set by the chain of q30 multiplier stages, one per table
// bit, plus the front and back stages
// reset (synchronous) empties the pipe and sets beta to 1.0 and mu to 0
module gaussian_basis_with_derivative import gbd_pkg::*; #(
   parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   gbd_req_if.sink                  req_ch,
   gbd_rsp_if.source                rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   csr_regs_type        regs;
   logic                advance;
   logic [EXP_TABLE_BITS:0] chain_v;
   exp_word_type        chain_word [0:EXP_TABLE_BITS];

   // configuration registers
   gbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .regs    (regs)
   );

   assign req_ch.ready = advance;

   // offset, square and exponent split
   gbd_front #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .distance  (req_ch.distance),
      .regs      (regs),
      .out_valid (chain_v[0]),
      .out_word  (chain_word[0])
   );

   // one table stage per resolved fraction bit
   for (genvar i = 0; i < EXP_TABLE_BITS; i++) begin : g_exp
      gbd_exp_stage #(.STAGE_IDX(i + 1)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_v[i]),
         .in_word   (chain_word[i]),
         .out_valid (chain_v[i+1]),
         .out_word  (chain_word[i+1])
      );
   end

   // value scaling, slope and output buffering
   gbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_v[EXP_TABLE_BITS]),
      .in_word     (chain_word[EXP_TABLE_BITS]),
      .advance     (advance),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .basis_value (rsp_ch.basis_value),
      .basis_slope (rsp_ch.basis_slope)
   );

endmodule

@@ hdl/gbd_checker.sv @@
// port-level checks of the gaussian basis block and the bind to its top level
// depends on gbd_pkg, gbd_rsp_if and gaussian_basis_with_derivative
module gbd_checker import gbd_pkg::*; (
   input logic       clock,
   input logic       reset,
   gbd_rsp_if.source rsp_ch
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=>
         $stable(rsp_ch.basis_value) && $stable(rsp_ch.basis_slope))
      else $error("result payload changed while stalled");

   // the basis value never exceeds 1.0
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.basis_value <= VALUE_ONE)
      else $error("basis value above 1.0");

   // a flushed value carries no slope
   a_zero_slope: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.basis_value == 16'd0) |-> rsp_ch.basis_slope == 18'sd0)
      else $error("nonzero slope with zero value");

   // reset empties the output side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid right after reset");

endmodule

bind gaussian_basis_with_derivative gbd_checker u_gbd_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);
